// File: design/hsv2rgb_pkg.sv
// Shared constants and types for the HSV to RGB converter.
package hsv2rgb_pkg;

    // Hue in tenths of a degree and the width of one 60-degree sector
    localparam int HUE_BITS = 12;
    localparam logic [HUE_BITS-1:0] HUE_MAX = 12'd3600;
    localparam int SPAN_BITS = 10;
    localparam logic [SPAN_BITS-1:0] SECTOR_SPAN = 10'd600;

    // Pipeline depth of one fade unit, request in to channel out
    localparam int FADE_LAT = 6;

    // Hue sectors, named by the colors at their two ends
    typedef enum logic [2:0] {
        SEC_RY = 3'd0,
        SEC_YG = 3'd1,
        SEC_GC = 3'd2,
        SEC_CB = 3'd3,
        SEC_BM = 3'd4,
        SEC_MR = 3'd5
    } t_sector;

endpackage

// File: design/hsv_to_rgb_converter.sv
// Pipeline: a request passes through 9 register stages in all (the front stages,
//   the sector delay line beside the fade units and the output register) to o_valid.
// Throughput: one request per clock; the pipeline never stalls, so busy is low
//   outside reset and o_valid is a one-cycle strobe for each request.
// Reset: synchronous, active low; clears all valid bits and holds busy high.
module hsv_to_rgb_converter #(
    parameter int CHANNEL_BITS = 8
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic [hsv2rgb_pkg::HUE_BITS-1:0]    i_hue,
    input  logic [CHANNEL_BITS-1:0]             i_saturation,
    input  logic [CHANNEL_BITS-1:0]             i_brightness,
    output logic                                o_valid,
    output logic [CHANNEL_BITS-1:0]             o_red,
    output logic [CHANNEL_BITS-1:0]             o_green,
    output logic [CHANNEL_BITS-1:0]             o_blue
);
    import hsv2rgb_pkg::*;

    localparam int N = CHANNEL_BITS;
    localparam int W = N + SPAN_BITS;

    logic                  n_valid1;
    logic [HUE_BITS-1:0]   n_hue;
    logic [HUE_BITS-1:0]   n_base;
    t_sector               n_sec;
    logic [SPAN_BITS-1:0]  n_frac;

    logic                  r_valid1;
    t_sector               r_sec1;
    logic [SPAN_BITS-1:0]  r_frac1;
    logic [N-1:0]          r_sat1;
    logic [N-1:0]          r_val1;

    logic                  r_valid2;
    t_sector               r_sec2;
    logic [N-1:0]          r_val2;
    logic [W-1:0]          r_fs_p2;
    logic [W-1:0]          r_fs_q2;
    logic [W-1:0]          r_fs_t2;

    logic                  r_dly_valid [FADE_LAT];
    t_sector               r_dly_sec   [FADE_LAT];
    logic [N-1:0]          r_dly_v     [FADE_LAT];

    logic                  w_vld_p;
    logic                  w_vld_q;
    logic                  w_vld_t;
    logic [N-1:0]          w_chan_p;
    logic [N-1:0]          w_chan_q;
    logic [N-1:0]          w_chan_t;

    logic [N-1:0]          n_red;
    logic [N-1:0]          n_green;
    logic [N-1:0]          n_blue;
    logic                  r_out_valid;
    logic [N-1:0]          r_red;
    logic [N-1:0]          r_green;
    logic [N-1:0]          r_blue;

    assign busy     = ~i_rst_n;
    assign n_valid1 = start & ~busy;

    // Clamp hue, pick the sector and the fraction within it
    always_comb begin
        n_hue = (i_hue > HUE_MAX) ? HUE_MAX : i_hue;
        if (n_hue >= HUE_BITS'(5 * int'(SECTOR_SPAN))) begin
            n_sec  = SEC_MR;
            n_base = HUE_BITS'(5 * int'(SECTOR_SPAN));
        end else if (n_hue >= HUE_BITS'(4 * int'(SECTOR_SPAN))) begin
            n_sec  = SEC_BM;
            n_base = HUE_BITS'(4 * int'(SECTOR_SPAN));
        end else if (n_hue >= HUE_BITS'(3 * int'(SECTOR_SPAN))) begin
            n_sec  = SEC_CB;
            n_base = HUE_BITS'(3 * int'(SECTOR_SPAN));
        end else if (n_hue >= HUE_BITS'(2 * int'(SECTOR_SPAN))) begin
            n_sec  = SEC_GC;
            n_base = HUE_BITS'(2 * int'(SECTOR_SPAN));
        end else if (n_hue >= HUE_BITS'(SECTOR_SPAN)) begin
            n_sec  = SEC_YG;
            n_base = HUE_BITS'(SECTOR_SPAN);
        end else begin
            n_sec  = SEC_RY;
            n_base = '0;
        end
        n_frac = SPAN_BITS'(n_hue - n_base);
    end

    // Advance valid bits through front stages, delay line and output
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid1    <= 1'b0;
            r_valid2    <= 1'b0;
            r_out_valid <= 1'b0;
            for (int i = 0; i < FADE_LAT; i++) begin
                r_dly_valid[i] <= 1'b0;
            end
        end else begin
            r_valid1       <= n_valid1;
            r_valid2       <= r_valid1;
            r_dly_valid[0] <= r_valid2;
            for (int i = 1; i < FADE_LAT; i++) begin
                r_dly_valid[i] <= r_dly_valid[i-1];
            end
            r_out_valid    <= r_dly_valid[FADE_LAT-1];
        end
    end

    // Capture the request, then form the three saturation weights
    always_ff @(posedge i_clk) begin
        r_sec1  <= n_sec;
        r_frac1 <= n_frac;
        r_sat1  <= i_saturation;
        r_val1  <= i_brightness;

        r_sec2  <= r_sec1;
        r_val2  <= r_val1;
        r_fs_p2 <= W'(SECTOR_SPAN) * W'(r_sat1);
        r_fs_q2 <= W'(r_frac1) * W'(r_sat1);
        r_fs_t2 <= W'(SPAN_BITS'(SECTOR_SPAN - r_frac1)) * W'(r_sat1);
    end

    // Hold sector and value alongside the fade units
    always_ff @(posedge i_clk) begin
        r_dly_sec[0] <= r_sec2;
        r_dly_v[0]   <= r_val2;
        for (int i = 1; i < FADE_LAT; i++) begin
            r_dly_sec[i] <= r_dly_sec[i-1];
            r_dly_v[i]   <= r_dly_v[i-1];
        end
    end

    hsv2rgb_fade #(.CHANNEL_BITS(CHANNEL_BITS)) u_fade_p (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_valid2),
        .i_v     (r_val2),
        .i_fs    (r_fs_p2),
        .o_valid (w_vld_p),
        .o_chan  (w_chan_p)
    );

    hsv2rgb_fade #(.CHANNEL_BITS(CHANNEL_BITS)) u_fade_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_valid2),
        .i_v     (r_val2),
        .i_fs    (r_fs_q2),
        .o_valid (w_vld_q),
        .o_chan  (w_chan_q)
    );

    hsv2rgb_fade #(.CHANNEL_BITS(CHANNEL_BITS)) u_fade_t (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_valid2),
        .i_v     (r_val2),
        .i_fs    (r_fs_t2),
        .o_valid (w_vld_t),
        .o_chan  (w_chan_t)
    );

    // Route v, p, q and t to the channels by sector
    always_comb begin
        case (r_dly_sec[FADE_LAT-1])
            SEC_RY: begin
                n_red = r_dly_v[FADE_LAT-1]; n_green = w_chan_t; n_blue = w_chan_p;
            end
            SEC_YG: begin
                n_red = w_chan_q; n_green = r_dly_v[FADE_LAT-1]; n_blue = w_chan_p;
            end
            SEC_GC: begin
                n_red = w_chan_p; n_green = r_dly_v[FADE_LAT-1]; n_blue = w_chan_t;
            end
            SEC_CB: begin
                n_red = w_chan_p; n_green = w_chan_q; n_blue = r_dly_v[FADE_LAT-1];
            end
            SEC_BM: begin
                n_red = w_chan_t; n_green = w_chan_p; n_blue = r_dly_v[FADE_LAT-1];
            end
            default: begin
                n_red = r_dly_v[FADE_LAT-1]; n_green = w_chan_p; n_blue = w_chan_q;
            end
        endcase
    end

    // Register the result
    always_ff @(posedge i_clk) begin
        r_red   <= n_red;
        r_green <= n_green;
        r_blue  <= n_blue;
    end

    assign o_valid = r_out_valid;
    assign o_red   = r_red;
    assign o_green = r_green;
    assign o_blue  = r_blue;

    a_top_align: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_vld_p == r_dly_valid[FADE_LAT-1]) && (w_vld_q == r_dly_valid[FADE_LAT-1])
        && (w_vld_t == r_dly_valid[FADE_LAT-1]))
        else $error("fade units out of step with sector delay line");

    a_top_lat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(start && !busy, FADE_LAT + 3))
        else $error("result strobe without an accepted request");

    a_top_rst: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result strobe right after reset");

endmodule

// File: design/hsv2rgb_fade.sv
// Pipelined fade unit: chan = v - ceil(v * fs / (600 * MAXC)).
module hsv2rgb_fade #(
    parameter int CHANNEL_BITS = 8
) (
    input  logic                                            i_clk,
    input  logic                                            i_rst_n,
    input  logic                                            i_valid,
    input  logic [CHANNEL_BITS-1:0]                         i_v,
    input  logic [CHANNEL_BITS+hsv2rgb_pkg::SPAN_BITS-1:0]  i_fs,
    output logic                                            o_valid,
    output logic [CHANNEL_BITS-1:0]                         o_chan
);
    import hsv2rgb_pkg::*;

    localparam int N  = CHANNEL_BITS;
    localparam int N2 = 2 * N;
    localparam int NA = N2 + 1;
    localparam int W  = N + SPAN_BITS;
    localparam int K  = W + SPAN_BITS;
    localparam int RW = K - SPAN_BITS + 1;
    localparam int PW = W + RW;
    localparam longint unsigned RECIP_L =
        ((64'd1 << K) + 64'(SECTOR_SPAN) - 64'd1) / 64'(SECTOR_SPAN);
    localparam logic [RW-1:0] RECIP = RW'(RECIP_L);
    localparam logic [N-1:0]  MAXC = {N{1'b1}};
    localparam logic [N2-1:0] CEIL_ADD = N2'(MAXC) - N2'(1);
    localparam logic [W-1:0]  SPAN_ROUND = W'(SECTOR_SPAN) - W'(1);

    logic [FADE_LAT-1:0] r_vld;

    logic [PW-1:0]        r_prod1;
    logic [W-1:0]         r_fs1;
    logic [N-1:0]         r_v1;

    logic [N-1:0]         n_k;
    logic [SPAN_BITS-1:0] n_m;
    logic [N-1:0]         r_k2;
    logic [SPAN_BITS-1:0] r_m2;
    logic [N-1:0]         r_v2;

    logic [N2-1:0]        r_vk3;
    logic [W-1:0]         r_vm3;
    logic [N-1:0]         r_v3;

    logic [W-1:0]         n_y;
    logic [PW-1:0]        r_prod4;
    logic [N2-1:0]        r_vk4;
    logic [N-1:0]         r_v4;

    logic [N2-1:0]        n_x;
    logic [N2-1:0]        r_x5;
    logic [N-1:0]         r_v5;

    logic [NA-1:0]        n_a;
    logic [N:0]           n_chan;
    logic [N-1:0]         r_chan6;

    // Advance valid bits with the data
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[FADE_LAT-2:0], i_valid};
        end
    end

    // Split fs into k * 600 + m, then form v*k + ceil(v*m/600), then ceil over MAXC
    always_comb begin
        n_k    = r_prod1[K +: N];
        n_m    = SPAN_BITS'(r_fs1 - W'(n_k) * W'(SECTOR_SPAN));
        n_y    = r_vm3 + SPAN_ROUND;
        n_x    = r_vk4 + N2'(r_prod4[K +: N]) + CEIL_ADD;
        n_a    = NA'(r_x5) + NA'(r_x5 >> N) + NA'(1);
        n_chan = {1'b0, r_v5} - n_a[N +: N + 1];
    end

    // Register the products and sums of each step of the divide and fade chain
    always_ff @(posedge i_clk) begin
        r_prod1 <= PW'(i_fs) * PW'(RECIP);
        r_fs1   <= i_fs;
        r_v1    <= i_v;

        r_k2    <= n_k;
        r_m2    <= n_m;
        r_v2    <= r_v1;

        r_vk3   <= N2'(r_v2) * N2'(r_k2);
        r_vm3   <= W'(r_v2) * W'(r_m2);
        r_v3    <= r_v2;

        r_prod4 <= PW'(n_y) * PW'(RECIP);
        r_vk4   <= r_vk3;
        r_v4    <= r_v3;

        r_x5    <= n_x;
        r_v5    <= r_v4;

        r_chan6 <= N'(n_chan);
    end

    assign o_valid = r_vld[FADE_LAT-1];
    assign o_chan  = r_chan6;

    a_fade_lat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(i_valid, FADE_LAT))
        else $error("fade result without matching request");

    a_fade_rem: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[1] |-> (r_m2 < SECTOR_SPAN))
        else $error("reciprocal divide left remainder out of range");

    a_fade_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_chan <= $past(i_v, FADE_LAT)))
        else $error("fade result exceeds value");

endmodule

// File: tb/tb_hsv_to_rgb_converter.sv
// Self-checking testbench for the HSV to RGB converter: directed and random requests.
`timescale 1ns / 1ps

module tb_hsv_to_rgb_converter;
    import hsv2rgb_pkg::*;

    localparam int CHANNEL_BITS = 8;
    localparam longint unsigned FULL_SCALE = (64'd1 << CHANNEL_BITS) - 1;
    localparam int RANDOM_REQUESTS = 400;
    localparam int DRAIN_CYCLES = 16;
    localparam int CYCLE_LIMIT = 100000;

    // Expected colors for accepted requests, checked in order against the strobed results
    class rgb_scoreboard;
        typedef struct {
            logic [CHANNEL_BITS-1:0] red;
            logic [CHANNEL_BITS-1:0] green;
            logic [CHANNEL_BITS-1:0] blue;
        } t_rgb_color;

        t_rgb_color expected_rgb[$];
        int mismatches;

        function new();
            mismatches = 0;
        endfunction

        function longint unsigned clamp_channel(longint unsigned x);
            return (x > FULL_SCALE) ? FULL_SCALE : x;
        endfunction

        // Work out the color of one accepted request and queue it
        function void note_request(logic [HUE_BITS-1:0] hue,
                                   logic [CHANNEL_BITS-1:0] sat,
                                   logic [CHANNEL_BITS-1:0] val);
            longint unsigned h, s, v, sec, frac, span_scale, p, q, t, r, g, b;
            t_sector sector;
            t_rgb_color color;
            h = 64'(hue);
            s = 64'(sat);
            v = 64'(val);
            // Saturate hue at a full turn; 3600 stays in the last sector
            if (h > HUE_MAX) begin
                h = HUE_MAX;
            end
            sec = h / SECTOR_SPAN;
            if (sec > 5) begin
                sec = 5;
            end
            frac = h - sec * SECTOR_SPAN;
            sector = t_sector'(sec[2:0]);
            span_scale = SECTOR_SPAN * FULL_SCALE;
            p = clamp_channel(v * (FULL_SCALE - s) / FULL_SCALE);
            q = clamp_channel(v * (span_scale - frac * s) / span_scale);
            t = clamp_channel(v * (span_scale - (SECTOR_SPAN - frac) * s) / span_scale);
            // Route the products to the channels by sector
            case (sector)
                SEC_RY: begin r = v; g = t; b = p; end
                SEC_YG: begin r = q; g = v; b = p; end
                SEC_GC: begin r = p; g = v; b = t; end
                SEC_CB: begin r = p; g = q; b = v; end
                SEC_BM: begin r = t; g = p; b = v; end
                default: begin r = v; g = p; b = q; end
            endcase
            color.red   = CHANNEL_BITS'(clamp_channel(r));
            color.green = CHANNEL_BITS'(clamp_channel(g));
            color.blue  = CHANNEL_BITS'(clamp_channel(b));
            expected_rgb.insert(expected_rgb.size(), color);
        endfunction

        function void compare_channel(string name, logic [CHANNEL_BITS-1:0] want,
                                      logic [CHANNEL_BITS-1:0] got);
            if (got !== want) begin
                $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
                mismatches++;
            end
        endfunction

        // Check one strobed result against the oldest expected color
        function void check_result(logic [CHANNEL_BITS-1:0] red,
                                   logic [CHANNEL_BITS-1:0] green,
                                   logic [CHANNEL_BITS-1:0] blue);
            t_rgb_color want;
            if (expected_rgb.size() == 0) begin
                $display("%0t: unexpected result, expected none, got %0d %0d %0d",
                         $time, red, green, blue);
                mismatches++;
            end else begin
                want = expected_rgb[0];
                expected_rgb.delete(0);
                compare_channel("red", want.red, red);
                compare_channel("green", want.green, green);
                compare_channel("blue", want.blue, blue);
            end
        endfunction
    endclass

    logic                    i_clk;
    logic                    i_rst_n;
    logic                    start;
    logic                    busy;
    logic [HUE_BITS-1:0]     i_hue;
    logic [CHANNEL_BITS-1:0] i_saturation;
    logic [CHANNEL_BITS-1:0] i_brightness;
    logic                    o_valid;
    logic [CHANNEL_BITS-1:0] o_red;
    logic [CHANNEL_BITS-1:0] o_green;
    logic [CHANNEL_BITS-1:0] o_blue;

    rgb_scoreboard color_board = new();
    bit no_idle = 1'b0;
    int cycle_count = 0;

    hsv_to_rgb_converter #(
        .CHANNEL_BITS(CHANNEL_BITS)
    ) uut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .start(start),
        .busy(busy),
        .i_hue(i_hue),
        .i_saturation(i_saturation),
        .i_brightness(i_brightness),
        .o_valid(o_valid),
        .o_red(o_red),
        .o_green(o_green),
        .o_blue(o_blue)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // Abort a run that hangs
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("%0t: timeout after %0d cycles", $time, cycle_count);
            $display("** hsv_to_rgb_converter: FAILED **");
            $finish;
        end
    end

    // Note accepted requests and check strobed results
    always @(posedge i_clk) begin
        if (i_rst_n === 1'b1 && start && busy === 1'b0) begin
            color_board.note_request(i_hue, i_saturation, i_brightness);
        end
        if (i_rst_n === 1'b1 && o_valid === 1'b1) begin
            color_board.check_result(o_red, o_green, o_blue);
        end
    end

    // Idle a random number of cycles, then hold the request until it is taken
    task automatic send_request(input logic [HUE_BITS-1:0] hue,
                                input logic [CHANNEL_BITS-1:0] sat,
                                input logic [CHANNEL_BITS-1:0] val);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 7);
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start <= 1'b1;
        i_hue <= hue;
        i_saturation <= sat;
        i_brightness <= val;
        do @(posedge i_clk); while (busy !== 1'b0);
    endtask

    // Favor the channel extremes now and then
    function automatic logic [CHANNEL_BITS-1:0] pick_channel();
        int roll;
        roll = $urandom_range(0, 9);
        if (roll == 0) begin
            return '0;
        end else if (roll == 1) begin
            return FULL_SCALE[CHANNEL_BITS-1:0];
        end
        return CHANNEL_BITS'($urandom_range(0, 32'(FULL_SCALE)));
    endfunction

    initial begin
        int roll;
        logic [HUE_BITS-1:0] hue;
        i_rst_n <= 1'b0;
        start <= 1'b0;
        i_hue <= '0;
        i_saturation <= '0;
        i_brightness <= '0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Sector edges, full turn, hue past a full turn, channel extremes
        send_request(12'd0, 8'd255, 8'd255);
        send_request(12'd0, 8'd0, 8'd0);
        send_request(12'd0, 8'd0, 8'd255);
        send_request(12'd0, 8'd255, 8'd0);
        send_request(12'd599, 8'd255, 8'd255);
        send_request(12'd600, 8'd255, 8'd255);
        send_request(12'd1199, 8'd255, 8'd255);
        send_request(12'd1200, 8'd255, 8'd255);
        send_request(12'd1799, 8'd200, 8'd180);
        send_request(12'd1800, 8'd255, 8'd255);
        send_request(12'd2400, 8'd255, 8'd255);
        send_request(12'd3000, 8'd255, 8'd255);
        send_request(12'd3599, 8'd255, 8'd255);
        send_request(12'd3600, 8'd255, 8'd255);
        send_request(12'd3600, 8'd128, 8'd77);
        send_request(12'd3601, 8'd255, 8'd255);
        send_request(12'd4095, 8'd255, 8'd255);
        send_request(12'd300, 8'd128, 8'd128);
        send_request(12'd2100, 8'd1, 8'd254);
        send_request(12'd2700, 8'd170, 8'd85);

        // Random colors, switching between idling and back-to-back stretches
        for (int n = 0; n < RANDOM_REQUESTS; n++) begin
            if (n % 50 == 0) begin
                no_idle = ($urandom_range(0, 2) == 0);
            end
            roll = $urandom_range(0, 9);
            if (roll == 0) begin
                hue = HUE_BITS'($urandom_range(32'(HUE_MAX) + 1, (1 << HUE_BITS) - 1));
            end else if (roll == 1) begin
                hue = HUE_BITS'(SECTOR_SPAN * $urandom_range(0, 6) - $urandom_range(0, 1));
                if (hue > HUE_MAX) begin
                    hue = HUE_MAX;
                end
            end else begin
                hue = HUE_BITS'($urandom_range(0, 32'(HUE_MAX)));
            end
            send_request(hue, pick_channel(), pick_channel());
        end
        start <= 1'b0;

        // Drain the pipeline
        while (color_board.expected_rgb.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (color_board.mismatches == 0) begin
            $display("** hsv_to_rgb_converter: PASSED **");
        end else begin
            $display("** hsv_to_rgb_converter: FAILED **");
        end
        $finish;
    end

endmodule
